[src/wtbc_pkg.sv]
// Types and constants shared by the word tokenizer modules.
package wtbc_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CfgIdxW = 1;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOD  = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_MAX_WORD_CHARS = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_BAD_CHAR_LIMIT = 1'b1;

    localparam logic [ByteW-1:0] MAX_WORD_CHARS_RST = 8'd254;
    localparam logic [ByteW-1:0] BAD_CHAR_LIMIT_RST = 8'd20;

    typedef struct packed {
        logic             is_word;
        logic             is_bad;
        logic [ByteW-1:0] lc;
    } t_byte_class;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [ByteW-1:0] out_char;
        logic             first_of_word;
        logic [ByteW-1:0] word_length;
    } t_result;

endpackage

[src/wtbc_classify.sv]
// Byte classifier: word character, non-text byte, lowercase form.
module wtbc_classify (
    input  logic [wtbc_pkg::ByteW-1:0] i_byte,
    output wtbc_pkg::t_byte_class      o_class
);
    import wtbc_pkg::*;

    logic w_upper;
    logic w_space;

    always_comb begin
        w_upper = i_byte inside {[8'h41:8'h5A]};
        w_space = i_byte inside {[8'd9:8'd13], 8'd32};
        o_class.is_word = i_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F};
        o_class.is_bad  = ((i_byte < 8'd32) || (i_byte > 8'd127)) && !w_space;
        o_class.lc      = w_upper ? (i_byte + 8'd32) : i_byte;
    end

endmodule

[src/wtbc_step.sv]
// Tokenizer state and per-item result logic.
module wtbc_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_op,
    input  wtbc_pkg::t_byte_class      i_class,
    input  logic [wtbc_pkg::ByteW-1:0] i_max_word_chars,
    input  logic [wtbc_pkg::ByteW-1:0] i_bad_char_limit,
    output wtbc_pkg::t_result          o_result
);
    import wtbc_pkg::*;

    logic             r_in_word;
    logic [ByteW-1:0] r_kept_length;
    logic [ByteW-1:0] r_bad_count;
    logic             r_aborted;
    logic             n_in_word;
    logic [ByteW-1:0] n_kept_length;
    logic [ByteW-1:0] n_bad_count;
    logic             n_aborted;

    always_comb begin
        n_in_word     = r_in_word;
        n_kept_length = r_kept_length;
        n_bad_count   = r_bad_count;
        n_aborted     = r_aborted;
        o_result      = '0;
        if (i_fire) begin
            if (i_op == OP_EOD) begin
                if (r_in_word && !r_aborted) begin
                    o_result.valid       = 1'b1;
                    o_result.kind        = KIND_END;
                    o_result.word_length = r_kept_length;
                end
                n_in_word     = 1'b0;
                n_kept_length = '0;
                n_bad_count   = '0;
                n_aborted     = 1'b0;
            end else if (!r_aborted) begin
                if (i_class.is_word) begin
                    if (!r_in_word) begin
                        n_in_word              = 1'b1;
                        n_kept_length          = 8'd1;
                        o_result.valid         = 1'b1;
                        o_result.kind          = KIND_CHAR;
                        o_result.out_char      = i_class.lc;
                        o_result.first_of_word = 1'b1;
                    end else if (r_kept_length < i_max_word_chars) begin
                        n_kept_length     = r_kept_length + 8'd1;
                        o_result.valid    = 1'b1;
                        o_result.kind     = KIND_CHAR;
                        o_result.out_char = i_class.lc;
                    end
                end else if (i_class.is_bad && (r_bad_count >= i_bad_char_limit)) begin
                    n_aborted      = 1'b1;
                    n_in_word      = 1'b0;
                    n_kept_length  = '0;
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_ABORT;
                end else begin
                    if (i_class.is_bad) begin
                        n_bad_count = r_bad_count + 8'd1;
                    end
                    if (r_in_word) begin
                        n_in_word            = 1'b0;
                        n_kept_length        = '0;
                        o_result.valid       = 1'b1;
                        o_result.kind        = KIND_END;
                        o_result.word_length = r_kept_length;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word     <= 1'b0;
            r_kept_length <= '0;
            r_bad_count   <= '0;
            r_aborted     <= 1'b0;
        end else begin
            r_in_word     <= n_in_word;
            r_kept_length <= n_kept_length;
            r_bad_count   <= n_bad_count;
            r_aborted     <= n_aborted;
        end
    end

endmodule

[src/word_tokenizer_with_binary_check_core.sv]
// Top level of the word tokenizer with binary-content check.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | i_valid / o_ready  | i_op, i_in_byte
//  result    | o_valid / i_ready  | o_kind, o_out_char, o_first_of_word,
//            |                    | o_word_length
//  config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  One request per cycle while the result side is not stalled; a taken request is held in the
//  request register, which feeds the classifier and state update, and these load the result
//  register in the same cycle.
//  Reset clears the pipeline valids and the word state and loads the config defaults.
//  A stalled result holds the result register and the request register behind it.
module word_tokenizer_with_binary_check_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [wtbc_pkg::ByteW-1:0]   i_in_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_kind,
    output logic [wtbc_pkg::ByteW-1:0]   o_out_char,
    output logic                         o_first_of_word,
    output logic [wtbc_pkg::ByteW-1:0]   o_word_length,
    input  logic                         i_cfg_we,
    input  logic [wtbc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [wtbc_pkg::ByteW-1:0]   i_cfg_data
);
    import wtbc_pkg::*;

    logic [ByteW-1:0] r_max_word;
    logic [ByteW-1:0] r_bad_limit;
    logic             r_req_valid;
    logic             r_req_op;
    logic [ByteW-1:0] r_req_byte;
    logic             r_out_valid;
    t_result          r_out;
    logic             w_advance;
    t_byte_class      w_class;
    t_result          w_result;

    assign w_advance = r_req_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_req_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_word  <= MAX_WORD_CHARS_RST;
            r_bad_limit <= BAD_CHAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_WORD_CHARS: r_max_word  <= i_cfg_data;
                CFG_BAD_CHAR_LIMIT: r_bad_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_ready) begin
            r_req_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req_op   <= i_op;
            r_req_byte <= i_in_byte;
        end
    end

    wtbc_classify u_classify (
        .i_byte  (r_req_byte),
        .o_class (w_class)
    );

    wtbc_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_advance),
        .i_op             (r_req_op),
        .i_class          (w_class),
        .i_max_word_chars (r_max_word),
        .i_bad_char_limit (r_bad_limit),
        .o_result         (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_out_char      = r_out.out_char;
    assign o_first_of_word = r_out.first_of_word;
    assign o_word_length   = r_out.word_length;

endmodule

[src/wtbc_checker.sv]
// Port-level checks for the word tokenizer core, bound to the top level.
module wtbc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [1:0]                   o_kind,
    input logic [wtbc_pkg::ByteW-1:0]   o_out_char,
    input logic                         o_first_of_word,
    input logic [wtbc_pkg::ByteW-1:0]   o_word_length
);
    import wtbc_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == KIND_CHAR || o_kind == KIND_END || o_kind == KIND_ABORT))
        else $error("illegal result kind");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_CHAR |-> o_word_length == '0 && o_out_char != '0)
        else $error("bad character result fields");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_END |->
            o_word_length != '0 && o_out_char == '0 && !o_first_of_word)
        else $error("bad word-end result fields");

    a_abort_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ABORT |->
            o_word_length == '0 && o_out_char == '0 && !o_first_of_word)
        else $error("bad abort result fields");

endmodule

bind word_tokenizer_with_binary_check_core wtbc_checker u_wtbc_checker (.*);
